// ===== sv/qacs_pkg.sv =====
// ----------------------------------------------------------------------------
// qacs_pkg
// Shared types and constants for the quote-aware character seek block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qacs_pkg;

  localparam int unsigned QUOTE_DEPTH_DEF = 8;
  localparam int unsigned INDEX_BITS_DEF  = 16;

  localparam int unsigned POS_W = 17;
  localparam int unsigned OFS_W = 16;

  // special bytes
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_BACKTICK  = 8'h60;

  // quote codes held on the stack
  localparam logic [1:0] QC_NONE     = 2'd0;
  localparam logic [1:0] QC_DQUOTE   = 2'd1;
  localparam logic [1:0] QC_SQUOTE   = 2'd2;
  localparam logic [1:0] QC_BACKTICK = 2'd3;

  // result status codes
  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_NONE     = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // skip modes
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_QUOTE = 2'd1;

  // configuration register indexes
  localparam logic [1:0] REG_TARGET = 2'd0;
  localparam logic [1:0] REG_MODE   = 2'd1;
  localparam logic [1:0] REG_FOLD   = 2'd2;
  localparam logic [1:0] REG_OFFSET = 2'd3;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stk_op_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] position;
  } result_t;

  function automatic logic [7:0] fold_upper(input logic [7:0] ch, input logic en);
    logic [7:0] res;
    res = ch;
    if (en && ch >= 8'h61 && ch <= 8'h7A) res = ch - 8'h20;
    return res;
  endfunction

  function automatic logic [1:0] quote_code(input logic [7:0] ch);
    logic [1:0] res;
    res = QC_NONE;
    if (ch == CH_DQUOTE) res = QC_DQUOTE;
    else if (ch == CH_SQUOTE) res = QC_SQUOTE;
    else if (ch == CH_BACKTICK) res = QC_BACKTICK;
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/qacs_stack.sv =====
// ----------------------------------------------------------------------------
// qacs_stack
// Quote stack: entries in a synchronous memory, top cached in a register and
// the entry below it prefetched every cycle so a pop needs no wait.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qacs_stack
  import qacs_pkg::*;
#(
  parameter int unsigned QUOTE_DEPTH = QUOTE_DEPTH_DEF,
  localparam int unsigned LW = $clog2(QUOTE_DEPTH + 1),
  localparam int unsigned AW = (QUOTE_DEPTH > 1) ? $clog2(QUOTE_DEPTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire stk_op_t       op_i,
  input  wire logic [1:0]    push_code_i,
  output logic      [LW-1:0] level_o,
  output logic      [1:0]    top_o
);

  logic [1:0]    mem_q [QUOTE_DEPTH];
  logic [1:0]    below_q;
  logic [1:0]    top_q, top_d;
  logic [LW-1:0] level_q, level_d;
  logic [LW-1:0] lvl_m2;
  logic [AW-1:0] waddr, raddr;

  always_comb begin
    level_d = level_q;
    if (op_i.clear) begin
      level_d = '0;
    end else if (op_i.push) begin
      level_d = level_q + LW'(1);
    end else if (op_i.pop) begin
      level_d = level_q - LW'(1);
    end
  end

  always_comb begin
    top_d = top_q;
    if (op_i.push) begin
      top_d = push_code_i;
    end else if (op_i.pop) begin
      top_d = below_q;
    end
  end

  // prefetch the entry that sits below the next top
  assign lvl_m2 = level_d - LW'(2);
  assign raddr  = ({1'b0, level_d} >= (LW + 1)'(2)) ? lvl_m2[AW-1:0] : '0;
  assign waddr  = level_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (op_i.push) begin
      mem_q[waddr] <= push_code_i;
    end
    below_q <= mem_q[raddr];
    top_q   <= top_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else begin
      level_q <= level_d;
    end
  end

  assign level_o = level_q;
  assign top_o   = top_q;

endmodule

`default_nettype wire

// ===== sv/qacs_outq.sv =====
// ----------------------------------------------------------------------------
// qacs_outq
// Two-entry result queue between the search logic and the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qacs_outq
  import qacs_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire result_t data_i,
  output logic         full_o,
  output logic         valid_o,
  input  wire logic    stall_i,
  output result_t      data_o
);

  result_t    slot0_q, slot1_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop = valid_o && !stall_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !pop) begin
      if (cnt_q == 2'd0) slot0_q <= data_i;
      else slot1_q <= data_i;
    end else if (pop && !push_i) begin
      slot0_q <= slot1_q;
    end else if (pop && push_i) begin
      if (cnt_q == 2'd1) begin
        slot0_q <= data_i;
      end else begin
        slot0_q <= slot1_q;
        slot1_q <= data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot0_q;

endmodule

`default_nettype wire

// ===== sv/quote_aware_char_seek.sv =====
// ----------------------------------------------------------------------------
// quote_aware_char_seek
// Streams a buffer byte by byte and reports the first byte that matches the
// target, skipping quoted spans and escapes as the skip mode selects.
// ----------------------------------------------------------------------------
// a result is registered in the two-entry output queue before it is offered
// throughput: one byte per cycle while the result queue is not full, set by the quote
//   stack read in each cycle (top cached in a register, the entry below prefetched from memory)
// reset clears configuration, stack level, escape, index and done flags;
//   stack memory contents are not cleared and no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module quote_aware_char_seek
  import qacs_pkg::*;
#(
  parameter int unsigned QUOTE_DEPTH = QUOTE_DEPTH_DEF,
  parameter int unsigned INDEX_BITS  = INDEX_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [OFS_W-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             last_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic      [1:0]       status_o,
  output logic      [POS_W-1:0] position_o
);

  localparam int unsigned LW = $clog2(QUOTE_DEPTH + 1);
  localparam int unsigned SW = (INDEX_BITS > POS_W) ? INDEX_BITS : POS_W;

  logic [7:0]       target_q;
  logic [1:0]       mode_q;
  logic             fold_q;
  logic [OFS_W-1:0] offset_q;

  logic [INDEX_BITS-1:0] idx_q, idx_d;
  logic                  esc_q, esc_d;
  logic                  done_q, done_d;

  logic [LW-1:0] level;
  logic [1:0]    top;
  stk_op_t       stk_op;
  logic [1:0]    qc;
  logic [7:0]    tgt, fb;
  logic          accept;
  logic          res_valid;
  result_t       res;
  logic [SW-1:0] pos_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      mode_q   <= '0;
      fold_q   <= 1'b0;
      offset_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TARGET: target_q <= cfg_wdata_i[7:0];
        REG_MODE:   mode_q   <= cfg_wdata_i[1:0];
        REG_FOLD:   fold_q   <= cfg_wdata_i[0];
        REG_OFFSET: offset_q <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  assign accept  = in_valid_i && !in_stall_o;
  assign qc      = quote_code(data_byte_i);
  assign tgt     = fold_upper(target_q, fold_q);
  assign fb      = fold_upper(data_byte_i, fold_q);
  assign pos_sum = SW'(offset_q) + SW'(idx_q);

  always_comb begin
    stk_op       = '0;
    esc_d        = esc_q;
    done_d       = done_q;
    idx_d        = idx_q;
    res_valid    = 1'b0;
    res.status   = ST_NONE;
    res.position = '0;
    if (accept) begin
      if (!done_q) begin
        if (esc_q) begin
          esc_d = 1'b0;
          if (level == '0 && data_byte_i == CH_BACKSLASH && tgt == CH_BACKSLASH) begin
            res_valid  = 1'b1;
            res.status = ST_FOUND;
          end
        end else if (mode_q == MODE_PLAIN) begin
          if (fb == tgt) begin
            res_valid  = 1'b1;
            res.status = ST_FOUND;
          end
        end else if (mode_q == MODE_QUOTE) begin
          if (level != '0) begin
            stk_op.pop = (qc != QC_NONE) && (qc == top);
          end else if (fb == tgt) begin
            res_valid  = 1'b1;
            res.status = ST_FOUND;
          end else begin
            stk_op.push = (qc != QC_NONE);
          end
        end else begin
          if (data_byte_i == CH_BACKSLASH) begin
            esc_d = 1'b1;
          end else if (level != '0 && qc != QC_NONE && qc == top) begin
            stk_op.pop = 1'b1;
          end else if (level == '0 && fb == tgt) begin
            res_valid  = 1'b1;
            res.status = ST_FOUND;
          end else if (qc != QC_NONE) begin
            if ({1'b0, level} >= (LW + 1)'(QUOTE_DEPTH)) begin
              res_valid  = 1'b1;
              res.status = ST_OVERFLOW;
            end else begin
              stk_op.push = 1'b1;
            end
          end
        end
        if (!res_valid && last_byte_i) begin
          res_valid  = 1'b1;
          res.status = ST_NONE;
        end
        if (res.status == ST_FOUND) res.position = pos_sum[POS_W-1:0];
        if (res_valid) done_d = 1'b1;
      end
      if (last_byte_i) begin
        stk_op.clear = 1'b1;
        esc_d        = 1'b0;
        idx_d        = '0;
        done_d       = 1'b0;
      end else begin
        idx_d = idx_q + INDEX_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      esc_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      esc_q  <= esc_d;
      done_q <= done_d;
    end
  end

  qacs_stack #(
    .QUOTE_DEPTH(QUOTE_DEPTH)
  ) u_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (stk_op),
    .push_code_i(qc),
    .level_o    (level),
    .top_o      (top)
  );

  result_t out_res;

  qacs_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_valid),
    .data_i (res),
    .full_o (in_stall_o),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .data_o (out_res)
  );

  assign status_o   = out_res.status;
  assign position_o = out_res.position;

endmodule

`default_nettype wire

// ===== sv/qacs_chk.sv =====
// ----------------------------------------------------------------------------
// qacs_chk
// Port-level checks for the quote-aware character seek block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qacs_chk
  import qacs_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire logic [1:0]       status_o,
  input wire logic [POS_W-1:0] position_o
);

  // a stalled request keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(position_o))
    else $error("stalled result request changed");

  // results other than found carry position zero
  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_FOUND |-> position_o == '0)
    else $error("non-found result with nonzero position");

  // input stalls only while results are waiting
  a_stall_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // a result only appears after an accepted byte
  a_rose_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result appeared without an accepted byte");

endmodule

bind quote_aware_char_seek qacs_chk u_qacs_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .status_o   (status_o),
  .position_o (position_o)
);

`default_nettype wire
